>>> sv/ppt_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ppt_pkg
// Types, constants and helpers shared by the peer pointer table.
// ----------------------------------------------------------------------------
package ppt_pkg;

   // Table sizing
   localparam int MAX_PEERS = 16;
   localparam int IDX_W     = (MAX_PEERS > 1) ? $clog2(MAX_PEERS) : 1;
   localparam int CNT_W     = $clog2(MAX_PEERS + 1);

   // Get-all never returns more than this many entries
   localparam logic [4:0] OUT_LIMIT = 5'd16;

   localparam logic [47:0] TIMEOUT_RESET = 48'd5000000;

   // Opcodes
   localparam logic [2:0] OP_MOVE   = 3'd0;
   localparam logic [2:0] OP_HIDE   = 3'd1;
   localparam logic [2:0] OP_EXPIRE = 3'd2;
   localparam logic [2:0] OP_GET    = 3'd3;
   localparam logic [2:0] OP_ALL    = 3'd4;

   // Result status codes
   localparam logic [1:0] STAT_ENTRY      = 2'd0;
   localparam logic [1:0] STAT_NOT_FOUND  = 2'd1;
   localparam logic [1:0] STAT_NO_VISIBLE = 2'd2;

   typedef struct packed {
      logic [2:0]         opcode;
      logic [31:0]        peer_id;
      logic signed [15:0] pos_x;
      logic signed [15:0] pos_y;
      logic [47:0]        timestamp;
      logic [4:0]         get_limit;
   } req_type;

   typedef struct packed {
      logic [1:0]         status;
      logic [31:0]        out_peer_id;
      logic signed [15:0] out_x;
      logic signed [15:0] out_y;
      logic [47:0]        last_updated;
      logic               visible;
      logic               last;
   } rsp_type;

   // One table entry as stored in memory
   typedef struct packed {
      logic [31:0]        peer_id;
      logic signed [15:0] pos_x;
      logic signed [15:0] pos_y;
      logic [47:0]        stamp;
      logic               visible;
   } entry_type;

   localparam int ENTRY_W = $bits(entry_type);

   typedef enum logic [2:0] {
      S_IDLE,
      S_READ,
      S_CHECK,
      S_PUT,
      S_FINISH
   } state_type;

   typedef enum logic [2:0] {
      MODE_LOOKUP,
      MODE_SHIFT,
      MODE_HIDE,
      MODE_EXPIRE,
      MODE_GET,
      MODE_ALL
   } mode_type;

   // Build a result from a stored entry
   function automatic rsp_type entry_to_rsp(entry_type e, logic fin);
      rsp_type r;
      r.status       = STAT_ENTRY;
      r.out_peer_id  = e.peer_id;
      r.out_x        = e.pos_x;
      r.out_y        = e.pos_y;
      r.last_updated = e.stamp;
      r.visible      = e.visible;
      r.last         = fin;
      return r;
   endfunction

   // Build a single empty result carrying a status and an id
   function automatic rsp_type empty_rsp(logic [1:0] stat, logic [31:0] id);
      rsp_type r;
      r.status       = stat;
      r.out_peer_id  = id;
      r.out_x        = '0;
      r.out_y        = '0;
      r.last_updated = '0;
      r.visible      = 1'b0;
      r.last         = 1'b1;
      return r;
   endfunction

endpackage

>>> sv/ppt_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ppt_ram
// Generic single-write, single-read RAM with a registered read port.
// ----------------------------------------------------------------------------
module ppt_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                                          clock,
   input  logic                                          wr_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0]  wr_addr,
   input  logic [WIDTH-1:0]                              wr_data,
   input  logic                                          rd_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0]  rd_addr,
   output logic [WIDTH-1:0]                              rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   // Read port, data held until the next read
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

>>> sv/peer_pointer_table_with_aging.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// peer_pointer_table_with_aging
// Insertion-ordered table of remote pointers with move, hide-all, expire,
// get-one and get-all-visible operations. Entries live in one RAM; a
// sequencer walks them with read-modify-write steps.
// ----------------------------------------------------------------------------
//  channel   direction  handshake            payload
//  req       in         req_valid/req_ready  req_data (req_type)
//  rsp       out        rsp_valid/rsp_ready  rsp_data (rsp_type)
//  csr       in         csr_wr_en            csr_wr_data (timeout, 48 bit)
//
//  A request is accepted in S_IDLE; each scanned entry takes a RAM read
//  (S_READ) and a check/write back (S_CHECK). A move hit rewrites the entry in
//  place; a miss scans all entries, shifts each entry down a slot if full,
//  then appends in S_PUT. Hide-all and expire scan all entries; get and
//  get-all end with a result in S_FINISH. Sync reset empties the table and
//  restores the default timeout, no clearing pass. A full rsp register stalls get/get-all emits.
// ----------------------------------------------------------------------------
module peer_pointer_table_with_aging
   import ppt_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  req_type     req_data,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output rsp_type     rsp_data,
   input  logic        csr_wr_en,
   input  logic [47:0] csr_wr_data
);

   state_type         state_ff,   state_in;
   mode_type          mode_ff,    mode_in;
   req_type           req_ff,     req_in;
   logic [CNT_W-1:0]  idx_ff,     idx_in;
   logic [CNT_W-1:0]  count_ff,   count_in;
   logic [47:0]       timeout_ff;
   entry_type         pend_ff,    pend_in;
   logic              pend_vld_ff, pend_vld_in;
   logic [4:0]        sel_ff,     sel_in;
   logic [4:0]        limit_ff,   limit_in;
   rsp_type           rsp_ff,     rsp_in;
   logic              rsp_vld_ff, rsp_vld_in;

   // RAM ports
   logic              ram_wr_en;
   logic [IDX_W-1:0]  ram_wr_addr;
   entry_type         ram_wr_data;
   logic              ram_rd_en;
   logic [IDX_W-1:0]  ram_rd_addr;
   entry_type         ram_rd_data;

   logic              slot_free;
   logic              last_idx;
   logic              take;
   logic [CNT_W-1:0]  idx_next;
   logic [47:0]       age;
   entry_type         new_entry;

   ppt_ram #(
      .WIDTH (ENTRY_W),
      .DEPTH (MAX_PEERS)
   ) u_ram (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_en   (ram_rd_en),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   // Shared terms
   assign slot_free = !rsp_vld_ff || rsp_ready;
   assign last_idx  = (idx_ff == count_ff - CNT_W'(1));
   assign idx_next  = idx_ff + CNT_W'(1);
   assign age       = req_ff.timestamp - ram_rd_data.stamp;
   assign take      = ram_rd_data.visible && (sel_ff < limit_ff);

   always_comb begin
      new_entry.peer_id = req_ff.peer_id;
      new_entry.pos_x   = req_ff.pos_x;
      new_entry.pos_y   = req_ff.pos_y;
      new_entry.stamp   = req_ff.timestamp;
      new_entry.visible = 1'b1;
   end

   assign req_ready = (state_ff == S_IDLE);
   assign rsp_valid = rsp_vld_ff;
   assign rsp_data  = rsp_ff;

   // Sequencer: next state, RAM accesses and result generation
   always_comb begin
      state_in    = state_ff;
      mode_in     = mode_ff;
      req_in      = req_ff;
      idx_in      = idx_ff;
      count_in    = count_ff;
      pend_in     = pend_ff;
      pend_vld_in = pend_vld_ff;
      sel_in      = sel_ff;
      limit_in    = limit_ff;
      rsp_in      = rsp_ff;
      rsp_vld_in  = rsp_vld_ff && !rsp_ready;
      ram_wr_en   = 1'b0;
      ram_wr_addr = idx_ff[IDX_W-1:0];
      ram_wr_data = ram_rd_data;
      ram_rd_en   = 1'b0;
      ram_rd_addr = idx_ff[IDX_W-1:0];

      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               req_in      = req_data;
               idx_in      = '0;
               pend_vld_in = 1'b0;
               sel_in      = '0;
               limit_in    = (req_data.get_limit > OUT_LIMIT) ? OUT_LIMIT
                                                               : req_data.get_limit;
               unique case (req_data.opcode)
                  OP_MOVE: begin
                     mode_in  = MODE_LOOKUP;
                     state_in = (count_ff == '0) ? S_PUT : S_READ;
                  end
                  OP_HIDE: begin
                     mode_in  = MODE_HIDE;
                     state_in = (count_ff == '0) ? S_IDLE : S_READ;
                  end
                  OP_EXPIRE: begin
                     mode_in  = MODE_EXPIRE;
                     state_in = (count_ff == '0) ? S_IDLE : S_READ;
                  end
                  OP_GET: begin
                     mode_in  = MODE_GET;
                     state_in = (count_ff == '0) ? S_FINISH : S_READ;
                  end
                  OP_ALL: begin
                     mode_in  = MODE_ALL;
                     state_in = (count_ff == '0) ? S_FINISH : S_READ;
                  end
                  default: begin
                     state_in = S_IDLE;
                  end
               endcase
            end
         end

         // Issue the RAM read; shifting reads the entry above the write slot
         S_READ: begin
            ram_rd_en   = 1'b1;
            ram_rd_addr = (mode_ff == MODE_SHIFT) ? idx_next[IDX_W-1:0]
                                                  : idx_ff[IDX_W-1:0];
            state_in    = S_CHECK;
         end

         S_CHECK: begin
            unique case (mode_ff)
               MODE_LOOKUP: begin
                  if (ram_rd_data.peer_id == req_ff.peer_id) begin
                     ram_wr_en   = 1'b1;
                     ram_wr_data = new_entry;
                     state_in    = S_IDLE;
                  end else if (last_idx) begin
                     if (count_ff < CNT_W'(MAX_PEERS) || MAX_PEERS == 1) begin
                        state_in = S_PUT;
                     end else begin
                        mode_in  = MODE_SHIFT;
                        idx_in   = '0;
                        state_in = S_READ;
                     end
                  end else begin
                     idx_in   = idx_next;
                     state_in = S_READ;
                  end
               end

               // Evict the oldest entry by moving each one down a slot
               MODE_SHIFT: begin
                  ram_wr_en   = 1'b1;
                  ram_wr_data = ram_rd_data;
                  if (idx_ff == CNT_W'(MAX_PEERS - 2)) begin
                     state_in = S_PUT;
                  end else begin
                     idx_in   = idx_next;
                     state_in = S_READ;
                  end
               end

               MODE_HIDE, MODE_EXPIRE: begin
                  ram_wr_en   = 1'b1;
                  ram_wr_data = ram_rd_data;
                  if (mode_ff == MODE_HIDE || age > timeout_ff) begin
                     ram_wr_data.visible = 1'b0;
                  end
                  if (last_idx) begin
                     state_in = S_IDLE;
                  end else begin
                     idx_in   = idx_next;
                     state_in = S_READ;
                  end
               end

               MODE_GET: begin
                  if (ram_rd_data.peer_id == req_ff.peer_id) begin
                     pend_in     = ram_rd_data;
                     pend_vld_in = 1'b1;
                     state_in    = S_FINISH;
                  end else if (last_idx) begin
                     state_in = S_FINISH;
                  end else begin
                     idx_in   = idx_next;
                     state_in = S_READ;
                  end
               end

               // Hold one selected entry back so the final one can carry last
               MODE_ALL: begin
                  if (!(take && pend_vld_ff && !slot_free)) begin
                     if (take) begin
                        if (pend_vld_ff) begin
                           rsp_in     = entry_to_rsp(pend_ff, 1'b0);
                           rsp_vld_in = 1'b1;
                        end
                        pend_in     = ram_rd_data;
                        pend_vld_in = 1'b1;
                        sel_in      = sel_ff + 5'd1;
                     end
                     if (last_idx || (take && (sel_ff + 5'd1 == limit_ff))) begin
                        state_in = S_FINISH;
                     end else begin
                        idx_in   = idx_next;
                        state_in = S_READ;
                     end
                  end
               end

               default: begin
                  state_in = S_IDLE;
               end
            endcase
         end

         // Write the moved peer: append, or the top slot after eviction
         S_PUT: begin
            ram_wr_en   = 1'b1;
            ram_wr_data = new_entry;
            if (count_ff < CNT_W'(MAX_PEERS)) begin
               ram_wr_addr = count_ff[IDX_W-1:0];
               count_in    = count_ff + CNT_W'(1);
            end else begin
               ram_wr_addr = IDX_W'(MAX_PEERS - 1);
            end
            state_in = S_IDLE;
         end

         // Final result of get or get-all
         S_FINISH: begin
            if (slot_free) begin
               rsp_vld_in = 1'b1;
               if (pend_vld_ff) begin
                  rsp_in = entry_to_rsp(pend_ff, 1'b1);
               end else if (mode_ff == MODE_GET) begin
                  rsp_in = empty_rsp(STAT_NOT_FOUND, req_ff.peer_id);
               end else begin
                  rsp_in = empty_rsp(STAT_NO_VISIBLE, 32'd0);
               end
               state_in = S_IDLE;
            end
         end

         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= S_IDLE;
         count_ff    <= '0;
         pend_vld_ff <= 1'b0;
         rsp_vld_ff  <= 1'b0;
      end else begin
         state_ff    <= state_in;
         count_ff    <= count_in;
         pend_vld_ff <= pend_vld_in;
         rsp_vld_ff  <= rsp_vld_in;
      end
   end

   // Timeout register
   always_ff @(posedge clock) begin
      if (reset) begin
         timeout_ff <= TIMEOUT_RESET;
      end else if (csr_wr_en) begin
         timeout_ff <= csr_wr_data;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      mode_ff  <= mode_in;
      req_ff   <= req_in;
      idx_ff   <= idx_in;
      pend_ff  <= pend_in;
      sel_ff   <= sel_in;
      limit_ff <= limit_in;
      rsp_ff   <= rsp_in;
   end

endmodule
